>>> design/b64u_pkg.sv
// ----------------------------------------------------------------------------
// b64u_pkg: shared constants, entry type and alphabet function for the base64url stream encoder
// Group entry format passed from the front end to the back end, and the
// URL-safe base64 alphabet lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package b64u_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CharW  = 7;
  localparam int unsigned GroupW = 24;
  localparam int unsigned SextW  = 6;

  // One group of up to three bytes, MSB first, missing low bytes zero.
  // last_idx is the index of the final character to emit (1, 2 or 3).
  typedef struct packed {
    logic [GroupW-1:0] group;
    logic [1:0]        last_idx;
    logic              msg_last;
  } grp_entry_t;

  // Six-bit value to ASCII code of the URL-safe alphabet.
  function automatic logic [CharW-1:0] sext_to_char(input logic [SextW-1:0] v);
    logic [CharW-1:0] c;
    if (v < 6'd26) begin
      c = 7'd65 + {1'b0, v};
    end else if (v < 6'd52) begin
      c = 7'd71 + {1'b0, v};          // 'a' - 26
    end else if (v < 6'd62) begin
      c = {1'b0, v} - 7'd4;           // '0' - 52
    end else if (v == 6'd62) begin
      c = 7'd45;                      // '-'
    end else begin
      c = 7'd95;                      // '_'
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> design/b64u_if.sv
// ----------------------------------------------------------------------------
// b64u_byte_if / b64u_char_if: valid/ready channels of the encoder
// Raw byte channel in, encoded character channel out.
// ----------------------------------------------------------------------------
`default_nettype none

interface b64u_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       in_last;

  modport source (output valid, output data_byte, output in_last, input ready);
  modport sink   (input valid, input data_byte, input in_last, output ready);
endinterface

interface b64u_char_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       out_last;

  modport source (output valid, output out_char, output out_last, input ready);
  modport sink   (input valid, input out_char, input out_last, output ready);
endinterface

`default_nettype wire

>>> design/b64u_front.sv
// ----------------------------------------------------------------------------
// b64u_front: byte gatherer
// Collects bytes into 24-bit groups and pushes one entry per full group or
// per final partial group.
// ----------------------------------------------------------------------------
`default_nettype none

module b64u_front (
  input  wire logic                   clk,
  input  wire logic                   rst,
  b64u_byte_if.sink                   byte_in,
  output b64u_pkg::grp_entry_t        push_data,
  output logic                        push_valid,
  input  wire logic                   push_ready
);
  import b64u_pkg::*;

  logic [15:0] held_bytes;
  logic [1:0]  held_count;
  logic        need_push;
  logic        accept;

  // A count of three never occurs; treat it like two.
  assign need_push = held_count[1] | byte_in.in_last;
  assign byte_in.ready = push_ready;
  assign accept = byte_in.valid & push_ready;
  assign push_valid = byte_in.valid & need_push;

  always_comb begin
    push_data.msg_last = byte_in.in_last;
    if (held_count[1]) begin
      push_data.group    = {held_bytes, byte_in.data_byte};
      push_data.last_idx = 2'd3;
    end else if (held_count[0]) begin
      push_data.group    = {held_bytes[7:0], byte_in.data_byte, 8'h00};
      push_data.last_idx = 2'd2;
    end else begin
      push_data.group    = {byte_in.data_byte, 16'h0000};
      push_data.last_idx = 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_bytes <= '0;
      held_count <= '0;
    end else if (accept) begin
      if (need_push) begin
        held_bytes <= '0;
        held_count <= '0;
      end else begin
        held_bytes <= {held_bytes[7:0], byte_in.data_byte};
        held_count <= held_count + 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

>>> design/b64u_queue.sv
// ----------------------------------------------------------------------------
// b64u_queue: small group queue
// Circular buffer of group entries between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module b64u_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire b64u_pkg::grp_entry_t   push_data,
  input  wire logic                   push_valid,
  output logic                        push_ready,
  output b64u_pkg::grp_entry_t        pop_data,
  output logic                        pop_valid,
  input  wire logic                   pop_ready
);
  import b64u_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] Full    = CntW'(DEPTH);

  grp_entry_t      slots [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] fill;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (fill != Full);
  assign pop_valid  = (fill != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CntW'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> design/b64u_back.sv
// ----------------------------------------------------------------------------
// b64u_back: character emitter
// Splits each group into six-bit values, maps them to the alphabet and
// drives one character per beat through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module b64u_back (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire b64u_pkg::grp_entry_t   pop_data,
  input  wire logic                   pop_valid,
  output logic                        pop_ready,
  b64u_char_if.source                 char_out
);
  import b64u_pkg::*;

  logic             cur_valid;
  grp_entry_t       cur;
  logic [1:0]       cur_idx;
  logic             o_valid;
  logic [CharW-1:0] o_char;
  logic             o_last;
  logic             advance;
  logic             at_end;
  logic [SextW-1:0] sext;

  assign advance   = cur_valid & (~o_valid | char_out.ready);
  assign at_end    = (cur_idx == cur.last_idx);
  assign pop_ready = ~cur_valid | (advance & at_end);

  always_comb begin
    unique case (cur_idx)
      2'd0:    sext = cur.group[23:18];
      2'd1:    sext = cur.group[17:12];
      2'd2:    sext = cur.group[11:6];
      default: sext = cur.group[5:0];
    endcase
  end

  assign char_out.valid    = o_valid;
  assign char_out.out_char = o_char;
  assign char_out.out_last = o_last;

  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) begin
      cur <= pop_data;
    end
    if (advance) begin
      o_char <= sext_to_char(sext);
      o_last <= at_end & cur.msg_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      cur_idx   <= '0;
      o_valid   <= 1'b0;
    end else begin
      if (pop_ready) begin
        cur_valid <= pop_valid;
        cur_idx   <= '0;
      end else if (advance) begin
        cur_idx <= cur_idx + 2'd1;
      end
      if (advance) begin
        o_valid <= 1'b1;
      end else if (char_out.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> design/base64url_stream_encoder_unit.sv
// ----------------------------------------------------------------------------
// base64url_stream_encoder_unit: unpadded base64url stream encoder
// Raw bytes in, URL-safe base64 characters out, last mark carried through.
// ----------------------------------------------------------------------------
//
//   channel   dir   beat contents             notes
//   byte_in   in    data_byte[7:0], in_last   one raw byte per beat
//   char_out  out   out_char[6:0], out_last   one character per beat
//
// Output: a full group of three bytes leaves the port as four characters,
// paced by the single-character output register, which can load the next
// character while the current one is being taken.
// Reset: rst is synchronous, active high; clears held bytes, queue and
// output valid.
// Stalls: byte_in.ready drops whenever the group queue is full, whether or
// not the beat would push a group; char_out.ready low stalls the back end,
// and the front end only once the queue has filled.
// ----------------------------------------------------------------------------
`default_nettype none

module base64url_stream_encoder_unit #(
  parameter int unsigned QUEUE_DEPTH = 2   // group entries between front and back
) (
  input  wire logic    clk,
  input  wire logic    rst,
  b64u_byte_if.sink    byte_in,
  b64u_char_if.source  char_out
);
  import b64u_pkg::*;

  // Front end -> queue
  grp_entry_t push_data;
  logic       push_valid;
  logic       push_ready;

  // Queue -> back end
  grp_entry_t pop_data;
  logic       pop_valid;
  logic       pop_ready;

  // Gathers bytes, builds a group entry on the third byte or the final one.
  b64u_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_in    (byte_in),
    .push_data  (push_data),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  // Decouples byte intake from character output.
  b64u_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_data  (push_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_data   (pop_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready)
  );

  // Emits two, three or four characters per entry; pops the next entry on
  // the same beat as the final character so groups stream without gaps.
  b64u_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_data  (pop_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .char_out  (char_out)
  );

endmodule

`default_nettype wire
